// ===== src/cliq_pkg.sv =====
package cliq_pkg;

  // queue geometry; the depth is a power of two so ring wrap is a plain truncation
  localparam int QUEUE_DEPTH = 256;
  localparam int MAX_BURST   = 64;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int LIMIT_W     = 7;
  localparam int FILL_W      = 9;

  // character codes
  localparam logic [7:0] CHAR_BS  = 8'h08;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_DEL = 8'h7F;

  // request codes
  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ECHO   = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_EMPTY  = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  // feed outcomes
  typedef enum logic [1:0] {
    OUT_STORED  = 2'd0,
    OUT_DROPPED = 2'd1,
    OUT_ERASED  = 2'd2,
    OUT_REFUSED = 2'd3
  } outcome_t;

  // data source for a result emitted by the controller
  typedef enum logic [1:0] {
    DSEL_ZERO  = 2'd0,
    DSEL_BYTE  = 2'd1,
    DSEL_BS    = 2'd2,
    DSEL_SPACE = 2'd3
  } dsel_t;

  // controller to datapath
  typedef struct packed {
    logic     accept;
    logic     push;
    logic     erase;
    logic     pop;
    logic     outcome_load;
    outcome_t outcome;
    logic     emit;
    kind_t    kind;
    dsel_t    dsel;
    logic     last;
  } cliq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_erase;
    logic newest_lf;
    logic count_zero;
    logic count_full;
    logic echoable;
    logic echo_en;
    logic read_none;
    logic pop_final;
  } cliq_status_t;

endpackage

// ===== src/cliq_ctrl.sv =====
module cliq_ctrl
  import cliq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         op,
  input  cliq_status_t stat,
  output cliq_cmd_t    cmd,
  output logic         busy
);

  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_FEED_CHECK = 8'b0000_0010,
    ST_ERASE_BS1  = 8'b0000_0100,
    ST_ERASE_SP   = 8'b0000_1000,
    ST_ERASE_BS2  = 8'b0001_0000,
    ST_STATUS     = 8'b0010_0000,
    ST_READ       = 8'b0100_0000,
    ST_DRAIN      = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next       = state;
    cmd              = '0;
    cmd.outcome      = OUT_STORED;
    cmd.kind         = KIND_ECHO;
    cmd.dsel         = DSEL_ZERO;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = (op == OP_READ) ? ST_READ : ST_FEED_CHECK;
        end
      end
      ST_FEED_CHECK: begin
        cmd.outcome_load = 1'b1;
        state_next       = ST_STATUS;
        if (stat.is_erase) begin
          if (stat.count_zero || stat.newest_lf) begin
            cmd.outcome = OUT_REFUSED;
          end else begin
            cmd.erase   = 1'b1;
            cmd.outcome = OUT_ERASED;
            if (stat.echo_en) begin
              state_next = ST_ERASE_BS1;
            end
          end
        end else begin
          // echo goes out before the push so it carries the old count
          if (stat.echo_en && stat.echoable) begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_ECHO;
            cmd.dsel = DSEL_BYTE;
          end
          if (stat.count_full) begin
            cmd.outcome = OUT_DROPPED;
          end else begin
            cmd.push    = 1'b1;
            cmd.outcome = OUT_STORED;
          end
        end
      end
      ST_ERASE_BS1: begin
        cmd.emit   = 1'b1;
        cmd.dsel   = DSEL_BS;
        state_next = ST_ERASE_SP;
      end
      ST_ERASE_SP: begin
        cmd.emit   = 1'b1;
        cmd.dsel   = DSEL_SPACE;
        state_next = ST_ERASE_BS2;
      end
      ST_ERASE_BS2: begin
        cmd.emit   = 1'b1;
        cmd.dsel   = DSEL_BS;
        state_next = ST_STATUS;
      end
      ST_STATUS: begin
        cmd.emit   = 1'b1;
        cmd.kind   = KIND_STATUS;
        cmd.last   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ: begin
        if (stat.read_none) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_EMPTY;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.pop = 1'b1;
          if (stat.pop_final) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // final popped byte leaves the read port this cycle
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_pop_only_in_read: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (state == ST_READ))
    else $error("pop issued outside read state");

  a_drain_after_final: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> $past(cmd.pop) && $past(stat.pop_final))
    else $error("drain entered without a final pop");

  a_erase_echo_sequence: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ERASE_BS1) |=> (state == ST_ERASE_SP) ##1 (state == ST_ERASE_BS2)
      ##1 (state == ST_STATUS))
    else $error("erase echo sequence broken");
`endif

endmodule

// ===== src/cliq_datapath.sv =====
module cliq_datapath
  import cliq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  logic [LIMIT_W-1:0] read_limit,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  cliq_cmd_t          cmd,
  output cliq_status_t       stat,
  output logic               result_strobe,
  output logic [1:0]         kind,
  output logic [7:0]         data,
  output logic [1:0]         feed_outcome,
  output logic [FILL_W-1:0]  fill_level,
  output logic               last
);

  logic [7:0]         ring [QUEUE_DEPTH];
  logic [7:0]         ring_q;
  logic [ADDR_W-1:0]  read_pointer;
  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         cur_byte;
  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] taken;
  outcome_t           outcome_q;
  logic               echo_enable;
  logic               pop_d;
  logic               pop_last_d;

  logic [ADDR_W-1:0]  newest_addr;
  logic [ADDR_W-1:0]  tail_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_en;
  logic [LIMIT_W-1:0] taken_inc;
  logic [7:0]         emit_data;

  // ring addressing; wrap comes from the address width
  assign newest_addr = read_pointer + byte_count[ADDR_W-1:0] - ADDR_W'(1);
  assign tail_addr   = read_pointer + byte_count[ADDR_W-1:0];
  assign rd_en       = cmd.accept | cmd.pop;
  assign rd_addr     = cmd.accept ? newest_addr : read_pointer;
  assign taken_inc   = taken + LIMIT_W'(1);

  // ring memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring[tail_addr] <= cur_byte;
    end
    if (rd_en) begin
      ring_q <= ring[rd_addr];
    end
  end

  // request capture, cr folded to lf and read limit saturated
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_byte <= (rx_byte == CHAR_CR) ? CHAR_LF : rx_byte;
      limit    <= (read_limit > LIMIT_W'(MAX_BURST)) ? LIMIT_W'(MAX_BURST) : read_limit;
    end
    if (cmd.outcome_load) begin
      outcome_q <= cmd.outcome;
    end
  end

  // queue pointers and burst counter
  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer <= '0;
      byte_count   <= '0;
      taken        <= '0;
    end else begin
      if (cmd.accept) begin
        taken <= '0;
      end
      if (cmd.push) begin
        byte_count <= byte_count + COUNT_W'(1);
      end
      if (cmd.erase) begin
        byte_count <= byte_count - COUNT_W'(1);
      end
      if (cmd.pop) begin
        read_pointer <= read_pointer + ADDR_W'(1);
        byte_count   <= byte_count - COUNT_W'(1);
        taken        <= taken_inc;
      end
    end
  end

  // echo enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b1;
    end else if (cfg_write) begin
      echo_enable <= cfg_data;
    end
  end

  // popped byte arrives in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      pop_d <= 1'b0;
    end else begin
      pop_d <= cmd.pop;
    end
    pop_last_d <= stat.pop_final;
  end

  // status towards the controller
  always_comb begin
    stat.is_erase   = (cur_byte == CHAR_BS) || (cur_byte == CHAR_DEL);
    stat.newest_lf  = (ring_q == CHAR_LF);
    stat.count_zero = (byte_count == '0);
    stat.count_full = (byte_count == COUNT_W'(QUEUE_DEPTH));
    stat.echoable   = (cur_byte == CHAR_LF) ||
                      ((cur_byte >= CHAR_SP) && (cur_byte < CHAR_DEL));
    stat.echo_en    = echo_enable;
    stat.read_none  = (limit == '0) || (byte_count == '0);
    stat.pop_final  = (taken_inc == limit) || (byte_count == COUNT_W'(1));
  end

  // data for a controller result
  always_comb begin
    case (cmd.dsel)
      DSEL_BYTE:  emit_data = cur_byte;
      DSEL_BS:    emit_data = CHAR_BS;
      DSEL_SPACE: emit_data = CHAR_SP;
      default:    emit_data = 8'h00;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= pop_d | cmd.emit;
    end
    fill_level <= FILL_W'(byte_count);
    if (pop_d) begin
      kind         <= KIND_DATA;
      data         <= ring_q;
      feed_outcome <= OUT_STORED;
      last         <= pop_last_d;
    end else begin
      kind         <= cmd.kind;
      data         <= emit_data;
      feed_outcome <= (cmd.kind == KIND_STATUS) ? outcome_q : OUT_STORED;
      last         <= cmd.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_W'(QUEUE_DEPTH))
    else $error("byte count beyond queue depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.count_full)
    else $error("push into a full queue");

  a_no_remove_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop || cmd.erase) |-> !stat.count_zero)
    else $error("byte removed from an empty queue");

  a_single_source: assert property (@(posedge clk) disable iff (rst)
    !(pop_d && cmd.emit))
    else $error("popped byte and controller result collide");
`endif

endmodule

// ===== src/console_line_input_queue.sv =====
// cooked console input queue
// request channel: op, rx_byte and read_limit are taken at a clock edge with
// start high and busy low. op feed brings one received byte; op read pops up
// to read_limit bytes (saturated to 64) from a 256-byte ring.
// config: cfg_data is written to the echo enable register at an edge with
// cfg_write high; write it only while busy is low.
// results: each result shows on kind, data, feed_outcome, fill_level and last
// for one cycle with result_strobe high; last marks the final result of a
// request. the receiver cannot stall, so every strobe is a delivered result.
// timing: a feed keeps busy high through the check and status states, and for
// an erase echo through the backspace, space and backspace states in between;
// a read keeps busy high while it pops, one byte per cycle from the single read
// port of the ring memory, then through the drain state. an echo or an empty
// read result passes only the result register, a popped byte also the read
// port; the final result is on the ports in the first cycle with busy low again.
// reset: rst (synchronous) empties the queue, sets echo on and idles the
// controller; ring contents need no clearing since only stored bytes are read.
module console_line_input_queue
  import cliq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [7:0]         rx_byte,
  input  logic [LIMIT_W-1:0] read_limit,
  input  logic               cfg_write,
  input  logic               cfg_data,
  output logic               result_strobe,
  output logic [1:0]         kind,
  output logic [7:0]         data,
  output logic [1:0]         feed_outcome,
  output logic [FILL_W-1:0]  fill_level,
  output logic               last
);

  cliq_cmd_t    cmd;
  cliq_status_t stat;

  // sequencer
  cliq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // ring, pointers and result register
  cliq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (rx_byte),
    .read_limit    (read_limit),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .result_strobe (result_strobe),
    .kind          (kind),
    .data          (data),
    .feed_outcome  (feed_outcome),
    .fill_level    (fill_level),
    .last          (last)
  );

endmodule

// ===== dv/console_line_input_queue_test.sv =====
module console_line_input_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cliq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_CAP   = 60;

  // one result as seen on the output ports
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        data;
    outcome_t          outcome;
    logic [FILL_W-1:0] fill;
    logic              last;
  } console_result_t;

  // one row of the directed script; want holds the final result where typed
  typedef struct {
    logic               op;
    logic [7:0]         rx;
    logic [LIMIT_W-1:0] lim;
    bit                 typed;
    console_result_t    want;
  } script_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               op;
  logic [7:0]         rx_byte;
  logic [LIMIT_W-1:0] read_limit;
  logic               cfg_write;
  logic               cfg_data;
  logic               result_strobe;
  logic [1:0]         kind;
  logic [7:0]         data;
  logic [1:0]         feed_outcome;
  logic [FILL_W-1:0]  fill_level;
  logic               last;

  // shadow of the queue and echo register
  logic [7:0]         ring_shadow [QUEUE_DEPTH];
  logic [ADDR_W-1:0]  oldest_slot;
  int                 held;
  bit                 echo_on;

  console_result_t    console_out_q [$];
  int                 mismatch_count;
  int                 cycle_count;

  console_line_input_queue uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .rx_byte       (rx_byte),
    .read_limit    (read_limit),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .kind          (kind),
    .data          (data),
    .feed_outcome  (feed_outcome),
    .fill_level    (fill_level),
    .last          (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // directed script: reset state, each special byte, erase rules, read limits
  script_row_t script [20] = '{
    '{OP_READ, 8'h00, 7'd5,   1'b1, '{KIND_EMPTY,  8'h00, OUT_STORED,  9'd0, 1'b1}},
    '{OP_FEED, 8'h08, 7'd0,   1'b1, '{KIND_STATUS, 8'h00, OUT_REFUSED, 9'd0, 1'b1}},
    '{OP_FEED, 8'h41, 7'd0,   1'b1, '{KIND_STATUS, 8'h00, OUT_STORED,  9'd1, 1'b1}},
    '{OP_FEED, 8'h7F, 7'd0,   1'b1, '{KIND_STATUS, 8'h00, OUT_ERASED,  9'd0, 1'b1}},
    '{OP_FEED, 8'h0D, 7'd0,   1'b1, '{KIND_STATUS, 8'h00, OUT_STORED,  9'd1, 1'b1}},
    '{OP_FEED, 8'h08, 7'd0,   1'b1, '{KIND_STATUS, 8'h00, OUT_REFUSED, 9'd1, 1'b1}},
    '{OP_FEED, 8'h00, 7'd0,   1'b1, '{KIND_STATUS, 8'h00, OUT_STORED,  9'd2, 1'b1}},
    '{OP_FEED, 8'hFF, 7'd0,   1'b1, '{KIND_STATUS, 8'h00, OUT_STORED,  9'd3, 1'b1}},
    '{OP_FEED, 8'h20, 7'd0,   1'b1, '{KIND_STATUS, 8'h00, OUT_STORED,  9'd4, 1'b1}},
    '{OP_FEED, 8'h7E, 7'd0,   1'b1, '{KIND_STATUS, 8'h00, OUT_STORED,  9'd5, 1'b1}},
    '{OP_FEED, 8'h1F, 7'd0,   1'b1, '{KIND_STATUS, 8'h00, OUT_STORED,  9'd6, 1'b1}},
    '{OP_FEED, 8'h80, 7'd0,   1'b1, '{KIND_STATUS, 8'h00, OUT_STORED,  9'd7, 1'b1}},
    '{OP_FEED, 8'h7F, 7'd0,   1'b1, '{KIND_STATUS, 8'h00, OUT_ERASED,  9'd6, 1'b1}},
    '{OP_READ, 8'hA5, 7'd0,   1'b1, '{KIND_EMPTY,  8'h00, OUT_STORED,  9'd6, 1'b1}},
    '{OP_READ, 8'h00, 7'd2,   1'b0, '{KIND_ECHO,   8'h00, OUT_STORED,  9'd0, 1'b0}},
    '{OP_READ, 8'h00, 7'd127, 1'b0, '{KIND_ECHO,   8'h00, OUT_STORED,  9'd0, 1'b0}},
    '{OP_READ, 8'hFF, 7'd64,  1'b1, '{KIND_EMPTY,  8'h00, OUT_STORED,  9'd0, 1'b1}},
    '{OP_FEED, 8'h0A, 7'd127, 1'b1, '{KIND_STATUS, 8'h00, OUT_STORED,  9'd1, 1'b1}},
    '{OP_FEED, 8'h7F, 7'd0,   1'b1, '{KIND_STATUS, 8'h00, OUT_REFUSED, 9'd1, 1'b1}},
    '{OP_READ, 8'h00, 7'd1,   1'b1, '{KIND_DATA,   8'h0A, OUT_STORED,  9'd0, 1'b1}}
  };

  // queue a result carrying the current fill
  function automatic void post_console_result(kind_t k, logic [7:0] d, outcome_t oc,
                                              logic lst);
    console_out_q.push_back('{k, d, oc, FILL_W'(held), lst});
  endfunction

  // line discipline: works out every result of one accepted request
  task automatic line_discipline(input logic o, input logic [7:0] b,
                                 input logic [LIMIT_W-1:0] lim);
    logic [7:0]        c;
    logic [ADDR_W-1:0] newest;
    outcome_t          oc;
    int                burst;
    int                taken;
    c = (b == CHAR_CR) ? CHAR_LF : b;
    if (o == OP_FEED) begin
      if (c == CHAR_BS || c == CHAR_DEL) begin
        oc = OUT_REFUSED;
        newest = ADDR_W'(int'(oldest_slot) + held - 1);
        if (held > 0 && ring_shadow[newest] != CHAR_LF) begin
          held--;
          oc = OUT_ERASED;
          if (echo_on) begin
            post_console_result(KIND_ECHO, CHAR_BS, OUT_STORED, 1'b0);
            post_console_result(KIND_ECHO, CHAR_SP, OUT_STORED, 1'b0);
            post_console_result(KIND_ECHO, CHAR_BS, OUT_STORED, 1'b0);
          end
        end
        post_console_result(KIND_STATUS, 8'h00, oc, 1'b1);
      end else begin
        // echo goes out before the push
        if (echo_on && (c == CHAR_LF || (c >= CHAR_SP && c < CHAR_DEL)))
          post_console_result(KIND_ECHO, c, OUT_STORED, 1'b0);
        if (held < QUEUE_DEPTH) begin
          ring_shadow[ADDR_W'(int'(oldest_slot) + held)] = c;
          held++;
          oc = OUT_STORED;
        end else begin
          oc = OUT_DROPPED;
        end
        post_console_result(KIND_STATUS, 8'h00, oc, 1'b1);
      end
    end else begin
      burst = (int'(lim) > MAX_BURST) ? MAX_BURST : int'(lim);
      if (burst == 0 || held == 0) begin
        post_console_result(KIND_EMPTY, 8'h00, OUT_STORED, 1'b1);
      end else begin
        taken = 0;
        while (taken < burst && held > 0) begin
          c = ring_shadow[oldest_slot];
          oldest_slot = oldest_slot + 1'b1;
          held--;
          taken++;
          post_console_result(KIND_DATA, c, OUT_STORED, (taken == burst || held == 0));
        end
      end
    end
  endtask

  // hand one request to the block and predict once it is taken
  task automatic send_request(input logic o, input logic [7:0] b,
                              input logic [LIMIT_W-1:0] lim);
    op         <= o;
    rx_byte    <= b;
    read_limit <= lim;
    start      <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    line_discipline(o, b, lim);
  endtask

  // random sender gap
  task automatic maybe_pause(input bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // hold off until every predicted result is out
  task automatic drain_results();
    start <= 1'b0;
    while (console_out_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // echo register write while idle
  task automatic set_echo(input bit v);
    drain_results();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    echo_on = v;
  endtask

  // mostly line editing traffic, with reads and some noise bytes
  task automatic random_request(output logic o, output logic [7:0] b,
                                output logic [LIMIT_W-1:0] lim);
    int r;
    r   = $urandom_range(0, 99);
    o   = OP_FEED;
    b   = 8'($urandom_range(32, 126));
    lim = LIMIT_W'($urandom_range(0, 127));
    if (r < 28) begin
      o = OP_READ;
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0)
        lim = LIMIT_W'($urandom_range(1, 16));
    end else if (r < 42) begin
      b = $urandom_range(0, 1) ? CHAR_BS : CHAR_DEL;
    end else if (r < 52) begin
      b = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
    end else if (r < 62) begin
      b = 8'($urandom_range(0, 255));
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t: %s mismatch: got %0d, want %0d", $realtime, field, got, want);
  endtask

  // result checking against the oldest prediction
  always @(posedge clk) begin
    console_result_t want;
    if (!rst && result_strobe === 1'b1) begin
      if (console_out_q.size() == 0) begin
        report_mismatch("unexpected result, kind", int'(kind), -1);
      end else begin
        want = console_out_q.pop_front();
        if (kind !== want.kind) report_mismatch("kind", int'(kind), int'(want.kind));
        if (data !== want.data) report_mismatch("data", int'(data), int'(want.data));
        if (feed_outcome !== want.outcome)
          report_mismatch("feed_outcome", int'(feed_outcome), int'(want.outcome));
        if (fill_level !== want.fill)
          report_mismatch("fill_level", int'(fill_level), int'(want.fill));
        if (last !== want.last) report_mismatch("last", int'(last), int'(want.last));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("console_line_input_queue_test: done, errors");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic               o;
    logic [7:0]         b;
    logic [LIMIT_W-1:0] lim;
    rst            = 1'b1;
    start          = 1'b0;
    op             = OP_FEED;
    rx_byte        = 8'h00;
    read_limit     = '0;
    cfg_write      = 1'b0;
    cfg_data       = 1'b0;
    oldest_slot    = '0;
    held           = 0;
    echo_on        = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed script, final result typed where it is obvious
    foreach (script[i]) begin
      send_request(script[i].op, script[i].rx, script[i].lim);
      if (script[i].typed)
        console_out_q[console_out_q.size() - 1] = script[i].want;
      maybe_pause(1'b1);
    end

    // fill past full with echo off, then drop and erase at full with echo on
    set_echo(1'b0);
    repeat (QUEUE_DEPTH + 4) begin
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_BS || b == CHAR_DEL)
        b = CHAR_SP;
      send_request(OP_FEED, b, LIMIT_W'($urandom_range(0, 127)));
      maybe_pause(1'b1);
    end
    set_echo(1'b1);
    send_request(OP_FEED, 8'h78, '0);
    send_request(OP_FEED, CHAR_CR, '0);
    send_request(OP_FEED, 8'h9C, '0);
    send_request(OP_FEED, CHAR_DEL, '0);
    send_request(OP_FEED, 8'h79, '0);
    while (held > 0) begin
      send_request(OP_READ, 8'($urandom_range(0, 255)), $urandom_range(0, 1) ? 7'd64 : 7'd127);
      maybe_pause(1'b1);
    end
    send_request(OP_READ, 8'h00, 7'd64);

    // random traffic, echo toggled between phases, no gaps at the tail
    for (int i = 0; i < 110; i++) begin
      if (i == 40) set_echo(1'b0);
      if (i == 75) set_echo(1'b1);
      random_request(o, b, lim);
      send_request(o, b, lim);
      maybe_pause(i < 90);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("console_line_input_queue_test: done, clean");
    else
      $display("console_line_input_queue_test: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
src/cliq_pkg.sv
src/cliq_ctrl.sv
src/cliq_datapath.sv
src/console_line_input_queue.sv
dv/console_line_input_queue_test.sv
